/* src/double_spiral_pixel_remap_defines.svh */
// assertion macros shared by the remap rtl
// depends on: nothing; users provide aclk and aresetn in scope
`ifndef DOUBLE_SPIRAL_PIXEL_REMAP_DEFINES_SVH
`define DOUBLE_SPIRAL_PIXEL_REMAP_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define DSPR_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define DSPR_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/dspr_pkg.sv */
// package for the double spiral pixel remap: fixed widths, codes, inner pixel order
// depends on: nothing
package dspr_pkg;

    localparam int SIDE_W    = 8;
    localparam int CFG_ADDR_W = 1;

    localparam logic [CFG_ADDR_W-1:0] REG_GRID_WIDTH  = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_GRID_HEIGHT = 1'b1;

    typedef enum logic [1:0] {
        SIDE_TOP    = 2'd0,
        SIDE_RIGHT  = 2'd1,
        SIDE_BOTTOM = 2'd2,
        SIDE_LEFT   = 2'd3
    } side_t;

    // index is {side, row lsb, col lsb}
    localparam logic [1:0] PIXEL_ORDER [16] = '{
        2'd0, 2'd3, 2'd1, 2'd2,
        2'd0, 2'd1, 2'd3, 2'd2,
        2'd2, 2'd1, 2'd3, 2'd0,
        2'd2, 2'd3, 2'd1, 2'd0
    };

endpackage

/* src/dspr_divider.sv */
// pipelined restoring divider, one quotient bit per stage, with ready chain
// depends on: dspr_pkg, double_spiral_pixel_remap_defines.svh
`include "double_spiral_pixel_remap_defines.svh"

module dspr_divider #(
    parameter int QW = 7
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic [dspr_pkg::SIDE_W-1:0] divisor,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic                       in_outside,
    input  logic [dspr_pkg::SIDE_W+QW-1:0] in_lin,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic                       out_outside,
    output logic [QW-1:0]              out_quot,
    output logic [dspr_pkg::SIDE_W-1:0] out_rem
);

    localparam int LIN_W = dspr_pkg::SIDE_W + QW;

    logic             valid_reg   [QW];
    logic             outside_reg [QW];
    logic [LIN_W-1:0] rem_reg     [QW];
    logic [QW-1:0]    quot_reg    [QW];
    logic             stage_ready [QW+1];

    assign stage_ready[QW] = out_ready;
    assign in_ready        = stage_ready[0];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        localparam int BIT = QW - 1 - k;

        logic             valid_in;
        logic             outside_in;
        logic [LIN_W-1:0] rem_in;
        logic [QW-1:0]    quot_in;
        logic [LIN_W-1:0] shifted;
        logic             take;
        logic [LIN_W-1:0] rem_next;
        logic [QW-1:0]    quot_next;

        if (k == 0) begin : g_first
            assign valid_in   = in_valid;
            assign outside_in = in_outside;
            assign rem_in     = in_lin;
            assign quot_in    = '0;
        end else begin : g_rest
            assign valid_in   = valid_reg[k-1];
            assign outside_in = outside_reg[k-1];
            assign rem_in     = rem_reg[k-1];
            assign quot_in    = quot_reg[k-1];
        end

        assign stage_ready[k] = !valid_reg[k] || stage_ready[k+1];

        assign shifted   = LIN_W'(divisor) << BIT;
        assign take      = rem_in >= shifted;
        assign rem_next  = take ? (rem_in - shifted) : rem_in;
        assign quot_next = quot_in | (QW'(take) << BIT);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k] <= 1'b0;
            end else if (stage_ready[k]) begin
                valid_reg[k] <= valid_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (stage_ready[k]) begin
                outside_reg[k] <= outside_in;
                rem_reg[k]     <= rem_next;
                quot_reg[k]    <= quot_next;
            end
        end
    end

    assign out_valid   = valid_reg[QW-1];
    assign out_outside = outside_reg[QW-1];
    assign out_quot    = quot_reg[QW-1];
    assign out_rem     = rem_reg[QW-1][dspr_pkg::SIDE_W-1:0];

    `DSPR_ASSERT_IMP(a_rem_below_divisor,
        out_valid && !out_outside,
        rem_reg[QW-1] < LIN_W'(divisor),
        "divider remainder not below divisor")

endmodule

/* src/double_spiral_pixel_remap.sv */
// double spiral pixel remap: logical (col,row) to physical position on an led strip
// throughput: one transaction per cycle while m_tready is high; bubbles are squeezed out
// by a per-stage ready chain; QW = clog2(MAX_SIDE), 7 by default
// stages: box/ring depth, ring offset and base multiply, linear index, QW divide stages, output
// reset: synchronous active-low aresetn clears all valid bits, width and height return to 16
// depends on: dspr_pkg, dspr_divider, double_spiral_pixel_remap_defines.svh
`include "double_spiral_pixel_remap_defines.svh"

module double_spiral_pixel_remap #(
    parameter int MAX_SIDE = 128
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write port
    input  logic        cfg_wr_en,
    input  logic [dspr_pkg::CFG_ADDR_W-1:0] cfg_wr_addr,
    input  logic [7:0]  cfg_wr_data,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] col_in, [15:8] row_in
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [7:0] col_out (signed), [14:8] row_out, [15] zero
);

    localparam int QW    = $clog2(MAX_SIDE);
    localparam int SW    = dspr_pkg::SIDE_W;
    localparam int LIN_W = SW + QW;

    // effective side: saturate at the maximum, drop the low bit
    function automatic logic [SW-1:0] eff_side(input logic [SW-1:0] v);
        logic [SW-1:0] sat;
        sat = ({1'b0, v} > (SW+1)'(MAX_SIDE)) ? SW'(MAX_SIDE) : v;
        return {sat[SW-1:1], 1'b0};
    endfunction

    // config registers hold the effective sizes directly
    logic [SW-1:0] grid_width_reg;
    logic [SW-1:0] grid_height_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_width_reg  <= SW'(16);
            grid_height_reg <= SW'(16);
        end else if (cfg_wr_en) begin
            case (cfg_wr_addr)
                dspr_pkg::REG_GRID_WIDTH:  grid_width_reg  <= eff_side(cfg_wr_data);
                dspr_pkg::REG_GRID_HEIGHT: grid_height_reg <= eff_side(cfg_wr_data);
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // ready chain: each stage loads when empty or when the next one loads
    // ---------------------------------------------------------------
    logic p1_valid_reg, p2_valid_reg, p3_valid_reg, m_tvalid_reg;
    logic p1_en, p2_en, p3_en, out_en;
    logic div_in_ready, div_out_valid, div_out_outside;
    logic [QW-1:0] div_quot;
    logic [SW-1:0] div_rem;

    assign out_en   = !m_tvalid_reg || m_tready;
    assign p3_en    = !p3_valid_reg || div_in_ready;
    assign p2_en    = !p2_valid_reg || p3_en;
    assign p1_en    = !p1_valid_reg || p2_en;
    assign s_tready = p1_en;

    // ---------------------------------------------------------------
    // stage 1: outside check, box coordinates, ring depth
    // ---------------------------------------------------------------
    logic [7:0] col_in, row_in;
    logic [6:0] bx, by, bw, bh, dist_r, dist_b, min_a, min_b;
    logic       outside_next;
    logic [6:0] depth_next;

    assign col_in = s_tdata[7:0];
    assign row_in = s_tdata[15:8];

    assign bx     = col_in[7:1];
    assign by     = row_in[7:1];
    assign bw     = grid_width_reg[SW-1:1];
    assign bh     = grid_height_reg[SW-1:1];
    assign dist_r = bw - 7'd1 - bx;
    assign dist_b = bh - 7'd1 - by;
    assign min_a  = (bx < by) ? bx : by;
    assign min_b  = (dist_r < dist_b) ? dist_r : dist_b;

    assign outside_next = (col_in >= grid_width_reg) || (row_in >= grid_height_reg);
    assign depth_next   = (min_a < min_b) ? min_a : min_b;

    logic       p1_outside_reg, p1_x0_reg, p1_y0_reg;
    logic [6:0] p1_bx_reg, p1_by_reg, p1_bw_reg, p1_bh_reg, p1_depth_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else if (p1_en) begin
            p1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (p1_en) begin
            p1_outside_reg <= outside_next;
            p1_x0_reg      <= col_in[0];
            p1_y0_reg      <= row_in[0];
            p1_bx_reg      <= bx;
            p1_by_reg      <= by;
            p1_bw_reg      <= bw;
            p1_bh_reg      <= bh;
            p1_depth_reg   <= depth_next;
        end
    end

    // ---------------------------------------------------------------
    // stage 2: position within the ring, side, inner order, ring base product
    // ---------------------------------------------------------------
    logic [6:0]  rx, ry, rw, rh, depth2;
    logic [9:0]  rx10, ry10, rw10, rh10;
    logic [7:0]  span;
    logic [14:0] prod_next;
    logic [9:0]  offset_next;
    dspr_pkg::side_t side;
    logic [1:0]  inner_next;

    assign depth2 = {p1_depth_reg[5:0], 1'b0};
    assign rx     = p1_bx_reg - p1_depth_reg;
    assign ry     = p1_by_reg - p1_depth_reg;
    assign rw     = p1_bw_reg - depth2;
    assign rh     = p1_bh_reg - depth2;
    assign rx10   = 10'(rx);
    assign ry10   = 10'(ry);
    assign rw10   = 10'(rw);
    assign rh10   = 10'(rh);

    // boxes per ring scaled by depth: m*(bw+bh-2m), doubled in stage 3
    assign span      = 8'(p1_bw_reg) + 8'(p1_bh_reg) - 8'(depth2);
    assign prod_next = {8'd0, p1_depth_reg} * {7'd0, span};

    // clockwise walk from the top-left box of the ring
    always_comb begin
        if (ry == 7'd0) begin
            offset_next = rx10;
            side        = (rx == rw - 7'd1) ? dspr_pkg::SIDE_RIGHT : dspr_pkg::SIDE_TOP;
        end else if (rx == rw - 7'd1) begin
            offset_next = rw10 + ry10 - 10'd1;
            side        = dspr_pkg::SIDE_RIGHT;
        end else if (ry == rh - 7'd1) begin
            offset_next = (rw10 << 1) + rh10 - 10'd3 - rx10;
            side        = (rx == 7'd0) ? dspr_pkg::SIDE_LEFT : dspr_pkg::SIDE_BOTTOM;
        end else begin
            offset_next = (rw10 << 1) + (rh10 << 1) - 10'd4 - ry10;
            side        = dspr_pkg::SIDE_LEFT;
        end
    end

    assign inner_next = dspr_pkg::PIXEL_ORDER[{side, p1_y0_reg, p1_x0_reg}];

    logic        p2_outside_reg;
    logic [14:0] p2_prod_reg;
    logic [9:0]  p2_offset_reg;
    logic [1:0]  p2_inner_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p2_valid_reg <= 1'b0;
        end else if (p2_en) begin
            p2_valid_reg <= p1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (p2_en) begin
            p2_outside_reg <= p1_outside_reg;
            p2_prod_reg    <= prod_next;
            p2_offset_reg  <= offset_next;
            p2_inner_reg   <= inner_next;
        end
    end

    // ---------------------------------------------------------------
    // stage 3: linear pixel index = 4 * (2*prod + offset) + inner
    // ---------------------------------------------------------------
    logic [15:0] box_idx;
    logic [17:0] lin_full;

    assign box_idx  = {p2_prod_reg, 1'b0} + 16'(p2_offset_reg);
    assign lin_full = {box_idx, 2'b00} + 18'(p2_inner_reg);

    logic             p3_outside_reg;
    logic [LIN_W-1:0] p3_lin_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p3_valid_reg <= 1'b0;
        end else if (p3_en) begin
            p3_valid_reg <= p2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (p3_en) begin
            p3_outside_reg <= p2_outside_reg;
            p3_lin_reg     <= lin_full[LIN_W-1:0];
        end
    end

    // ---------------------------------------------------------------
    // column and row: linear index split by the effective width
    // ---------------------------------------------------------------
    dspr_divider #(
        .QW (QW)
    ) u_divider (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .divisor     (grid_width_reg),
        .in_valid    (p3_valid_reg),
        .in_ready    (div_in_ready),
        .in_outside  (p3_outside_reg),
        .in_lin      (p3_lin_reg),
        .out_valid   (div_out_valid),
        .out_ready   (out_en),
        .out_outside (div_out_outside),
        .out_quot    (div_quot),
        .out_rem     (div_rem)
    );

    // ---------------------------------------------------------------
    // output register: parts the result side from the pipeline
    // ---------------------------------------------------------------
    logic [QW+6:0]     quot_ext;
    logic signed [7:0] col_out_next, col_out_reg;
    logic [6:0]        row_out_next, row_out_reg;

    assign quot_ext     = {7'd0, div_quot};
    assign col_out_next = div_out_outside ? -8'sd1 : signed'(div_rem);
    assign row_out_next = div_out_outside ? 7'd0 : quot_ext[6:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_en) begin
            m_tvalid_reg <= div_out_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_en) begin
            col_out_reg <= col_out_next;
            row_out_reg <= row_out_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, row_out_reg, col_out_reg};

    // ---------------------------------------------------------------
    // checks
    // ---------------------------------------------------------------
    `DSPR_ASSERT_NXT(a_accept_loads_stage1,
        s_tvalid && s_tready,
        p1_valid_reg,
        "accepted transaction did not reach stage 1")

    `DSPR_ASSERT_IMP(a_depth_within_box,
        p1_valid_reg && !p1_outside_reg,
        (p1_depth_reg <= p1_bx_reg) && (p1_depth_reg <= p1_by_reg),
        "ring depth exceeds box coordinate")

    `DSPR_ASSERT_IMP(a_outside_result_form,
        m_tvalid_reg && (col_out_reg == -8'sd1),
        row_out_reg == 7'd0,
        "outside result carries nonzero row")

    `DSPR_ASSERT_IMP(a_inside_row_in_grid,
        m_tvalid_reg && (col_out_reg != -8'sd1),
        ({1'b0, row_out_reg} < grid_height_reg) && (col_out_reg[7] == 1'b0),
        "inside result outside the grid")

endmodule

/* dv/double_spiral_pixel_remap_tb.sv */
// self-checking testbench for double_spiral_pixel_remap: streams pixel coordinates through
// the remap under random idling and backpressure and checks each physical position it returns
// depends on: dspr_pkg and the double_spiral_pixel_remap rtl
module double_spiral_pixel_remap_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_SIDE = 128;
    // pipeline depth from the top level, plus margin before touching the registers
    localparam int PIPE_LATENCY = $clog2(MAX_SIDE) + 4;
    localparam int SETTLE_CYCLES = PIPE_LATENCY + 6;
    localparam int LONG_HOLD = 250;

    // pixel order inside one 2x2 box, indexed by {ring side, row lsb, col lsb}
    localparam int BOX_ORDER [16] = '{
        0, 3, 1, 2,    // top side
        0, 1, 3, 2,    // right side and top-right corner
        2, 1, 3, 0,    // bottom side
        2, 3, 1, 0     // left side and bottom-left corner
    };

    // directed coordinates on the 16x16 reset grid, packed as {row, col}
    localparam logic [15:0] CORNER_PIXELS [24] = '{
        16'h0000, 16'h0101, 16'h0100, 16'h0001,    // top-left box, all four pixels
        16'h000e, 16'h010f, 16'h000f,              // top-right corner box
        16'h0f0f, 16'h0e0e,                        // bottom-right corner box
        16'h0e00, 16'h0f01, 16'h0e01, 16'h0f00,    // bottom-left corner box
        16'h0f07, 16'h0e06,                        // bottom side
        16'h0700, 16'h0601,                        // left side
        16'h080f, 16'h0108,                        // right and top sides
        16'h0707, 16'h0808,                        // innermost ring
        16'h0310, 16'h1003, 16'hffff               // outside: column, row, both at max
    };

    // register settings at the edges: minimum, maximum, oversized, zero/one, odd, mixed
    localparam logic [7:0] EDGE_W [8] = '{8'd2, 8'd128, 8'd255, 8'd0, 8'd3, 8'd128, 8'd2, 8'd130};
    localparam logic [7:0] EDGE_H [8] = '{8'd2, 8'd128, 8'd255, 8'd1, 8'd129, 8'd2, 8'd128, 8'd7};

    typedef struct packed {
        logic [6:0]        row;
        logic signed [7:0] col;
    } strip_pos_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [dspr_pkg::CFG_ADDR_W-1:0] cfg_wr_addr = dspr_pkg::REG_GRID_WIDTH;
    logic [7:0]  cfg_wr_data = 8'd0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = 16'd0;    // [7:0] col_in, [15:8] row_in
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;            // [7:0] col_out (signed), [14:8] row_out, [15] zero

    // testbench copy of the grid registers, changed only while the block is idle
    logic [7:0] grid_w_reg = 8'd16;
    logic [7:0] grid_h_reg = 8'd16;

    logic [15:0] pending_pixels [$];    // coordinates waiting for the driver
    strip_pos_t  expected_pos [$];      // predicted positions, oldest first

    int error_count = 0;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int tx_gap_left = 0;
    int rx_stall_left = 0;
    int hold_requests = 0;
    int hold_seen = 0;
    int hold_left = 0;

    double_spiral_pixel_remap #(
        .MAX_SIDE(MAX_SIDE)
    ) dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_addr(cfg_wr_addr),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // register value as the block uses it: saturated, then rounded down to even
    function automatic int usable_side(logic [7:0] reg_val);
        int v;
        v = (reg_val > MAX_SIDE) ? MAX_SIDE : int'(reg_val);
        return v & ~1;
    endfunction

    // physical strip position of one logical pixel under the current grid size
    function automatic strip_pos_t spiral_position(logic [7:0] col, logic [7:0] row);
        int w, h, bx, by, bw, bh, ring, rx, ry, rw, rh, box, lin;
        dspr_pkg::side_t side;
        strip_pos_t pos;
        w = usable_side(grid_w_reg);
        h = usable_side(grid_h_reg);
        if (col >= w || row >= h) begin
            pos.col = -8'sd1;
            pos.row = '0;
            return pos;
        end
        bx = int'(col >> 1);
        by = int'(row >> 1);
        bw = w / 2;
        bh = h / 2;
        // ring depth is the distance to the nearest grid edge, in boxes
        ring = bx;
        if (by < ring) ring = by;
        if (bw - 1 - bx < ring) ring = bw - 1 - bx;
        if (bh - 1 - by < ring) ring = bh - 1 - by;
        rx = bx - ring;
        ry = by - ring;
        rw = bw - 2 * ring;
        rh = bh - 2 * ring;
        // all outer rings come first, then the clockwise walk of this one
        box = ring * 2 * (bw + bh - 2 * ring);
        if (ry == 0) begin
            box += rx;
            side = dspr_pkg::SIDE_TOP;
            if (rx == rw - 1) side = dspr_pkg::SIDE_RIGHT;
        end else if (rx == rw - 1) begin
            box += rw + ry - 1;
            side = dspr_pkg::SIDE_RIGHT;
        end else if (ry == rh - 1) begin
            box += 2 * rw + rh - 3 - rx;
            side = dspr_pkg::SIDE_BOTTOM;
            if (rx == 0) side = dspr_pkg::SIDE_LEFT;
        end else begin
            box += 2 * rw + 2 * rh - 4 - ry;
            side = dspr_pkg::SIDE_LEFT;
        end
        lin = box * 4 + BOX_ORDER[{side, row[0], col[0]}];
        pos.col = 8'(lin % w);
        pos.row = 7'(lin / w);
        return pos;
    endfunction

    // input driver: predicts on every accepted transaction, then offers the next coordinate
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                expected_pos.push_back(spiral_position(s_tdata[7:0], s_tdata[15:8]));
            // valid and data are held until the block takes them
            if (!s_tvalid || s_tready) begin
                if (tx_gap_left > 0) begin
                    tx_gap_left--;
                    s_tvalid <= 1'b0;
                end else if (pending_pixels.size() > 0 && tx_idle_pct > 0
                             && $urandom_range(99) < tx_idle_pct) begin
                    tx_gap_left = $urandom_range(18, 1) - 1;
                    s_tvalid <= 1'b0;
                end else if (pending_pixels.size() > 0) begin
                    s_tdata  <= pending_pixels.pop_front();
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor: checks each accepted transaction, then picks the next ready value
    always @(posedge aclk) begin : result_monitor
        strip_pos_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_pos.size() == 0) begin
                    $error("unexpected result transaction: m_tdata=%h", m_tdata);
                    error_count++;
                end else begin
                    want = expected_pos.pop_front();
                    if (m_tdata[7:0] !== want.col) begin
                        $error("col_out mismatch: expected %0d, actual %0d",
                               want.col, $signed(m_tdata[7:0]));
                        error_count++;
                    end
                    if (m_tdata[14:8] !== want.row) begin
                        $error("row_out mismatch: expected %0d, actual %0d",
                               want.row, m_tdata[14:8]);
                        error_count++;
                    end
                    if (m_tdata[15] !== 1'b0) begin
                        $error("tdata pad mismatch: expected 0, actual %b", m_tdata[15]);
                        error_count++;
                    end
                end
            end
            // a long hold-off on request fills the pipeline and backs up the input
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (hold_seen != hold_requests) begin
                hold_seen = hold_requests;
                hold_left = LONG_HOLD - 1;
                m_tready <= 1'b0;
            end else if (rx_stall_left > 0) begin
                rx_stall_left--;
                m_tready <= 1'b0;
            end else if (rx_idle_pct > 0 && $urandom_range(99) < rx_idle_pct) begin
                rx_stall_left = $urandom_range(18, 1) - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // wait until every offered coordinate came back, then let the pipeline go quiet
    // checked at the falling edge, when the driver's updates have all settled
    task automatic drain_results();
        do @(negedge aclk);
        while (pending_pixels.size() != 0 || s_tvalid || expected_pos.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // both registers written on consecutive edges, enable held high across them
    task automatic set_grid(logic [7:0] w, logic [7:0] h);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_addr <= dspr_pkg::REG_GRID_WIDTH;
        cfg_wr_data <= w;
        @(posedge aclk);
        cfg_wr_addr <= dspr_pkg::REG_GRID_HEIGHT;
        cfg_wr_data <= h;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        grid_w_reg = w;
        grid_h_reg = h;
    endtask

    // mostly pixels inside the grid, the rest anywhere in the 8-bit range
    task automatic queue_random_pixels(int count);
        int w, h;
        logic [7:0] c, r;
        w = usable_side(grid_w_reg);
        h = usable_side(grid_h_reg);
        repeat (count) begin
            c = (w > 0 && $urandom_range(99) < 85) ? 8'($urandom_range(w - 1))
                                                   : 8'($urandom_range(255));
            r = (h > 0 && $urandom_range(99) < 85) ? 8'($urandom_range(h - 1))
                                                   : 8'($urandom_range(255));
            pending_pixels.push_back({r, c});
        end
    endtask

    initial begin : stimulus
        logic [7:0] w, h;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // directed corners, sides and outside pixels on the reset 16x16 grid
        foreach (CORNER_PIXELS[i]) pending_pixels.push_back(CORNER_PIXELS[i]);
        drain_results();

        // receiver holds off while the sender keeps offering, then the receiver stalls at random
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        @(posedge aclk);
        hold_requests <= hold_requests + 1;
        queue_random_pixels(60);
        drain_results();
        rx_idle_pct = 30;
        queue_random_pixels(60);
        drain_results();

        // register extremes: smallest, largest, saturated, empty, odd, mixed
        foreach (EDGE_W[i]) begin
            set_grid(EDGE_W[i], EDGE_H[i]);
            tx_idle_pct = $urandom_range(2) * 20;
            rx_idle_pct = $urandom_range(2) * 20;
            queue_random_pixels(60);
            drain_results();
        end

        // random grid sizes, mostly legal even ones; the last phase runs without idling
        for (int k = 0; k < 12; k++) begin
            w = ($urandom_range(99) < 80) ? 8'($urandom_range(64, 1) * 2) : 8'($urandom_range(255));
            h = ($urandom_range(99) < 80) ? 8'($urandom_range(64, 1) * 2) : 8'($urandom_range(255));
            set_grid(w, h);
            tx_idle_pct = (k == 11) ? 0 : $urandom_range(2) * 20;
            rx_idle_pct = (k == 11) ? 0 : $urandom_range(2) * 20;
            queue_random_pixels(90);
            drain_results();
        end

        if (expected_pos.size() != 0) begin
            $error("%0d expected results never arrived", expected_pos.size());
            error_count++;
        end
        if (error_count == 0) begin
            $display("** double_spiral_pixel_remap: PASSED **");
        end else begin
            $display("** double_spiral_pixel_remap: FAILED **");
        end
        $finish;
    end

    // watchdog, several times the slowest legal run
    initial begin : watchdog
        #5_000_000;
        $display("** double_spiral_pixel_remap: FAILED **");
        $finish;
    end

endmodule
